### design/jsbm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsbm_pkg
// Shared widths, codes, side-band structs and rounding helper.
// ----------------------------------------------------------------------------
package jsbm_pkg;

  localparam int Q_W      = 32;          // Q16.16 word
  localparam int DET_W    = 64;          // exact 2x2 determinant
  localparam int NUM_W    = 97;          // dividend: magnitude shifted up by 17 or 33
  localparam int QUO_W    = 62;          // quotient bits produced by a divider
  localparam int REM_W    = 65;          // partial remainder
  localparam int DEN_W    = 64;          // divisor
  localparam int MAG_W    = 63;          // rounded magnitude, cap 2^62
  localparam int RECIP_W  = 33;          // 1/d, at most 2^32
  localparam int SQ_W     = 66;          // recip squared
  localparam int FM_W     = 49;          // |1 - 1/d^2|
  localparam int ACC_W    = 113;         // fm * hm partial-product sum
  localparam int H_LANES  = 4;           // gradient lanes
  localparam int MIN_W    = 31;
  localparam int ADDR_W   = 3;

  localparam logic [MIN_W-1:0] MIN_DET_RESET = 31'd1;
  localparam logic [MAG_W-1:0] MAG_CAP       = 63'h4000_0000_0000_0000;
  localparam logic [31:0]      ONE_Q         = 32'h0001_0000;
  localparam logic [31:0]      ROUND_HALF    = 32'h0000_8000;
  localparam logic [Q_W-1:0]   SAT_POS       = 32'h7FFF_FFFF;
  localparam logic [Q_W-1:0]   SAT_NEG       = 32'h8000_0000;

  // register index (paddr[2])
  localparam logic REG_MIN_DET = 1'b0;

  // flags riding through the first divider
  typedef struct packed {
    logic                wzero;
    logic                dneg;
    logic [H_LANES-1:0]  hneg;
  } jsbm_pre_t;

  // operands riding through the reciprocal divider
  typedef struct packed {
    logic                            ok;
    logic [MAG_W-1:0]                dm;
    logic [H_LANES-1:0][MAG_W-1:0]   hm;
    logic [H_LANES-1:0]              hneg;
  } jsbm_side_t;

  // round half up of a quotient with one guard bit, or the cap
  function automatic logic [MAG_W-1:0] round_cap(input logic [QUO_W-1:0] q,
                                                 input logic cap);
    logic [QUO_W:0] s;
    s = {1'b0, q} + {{QUO_W{1'b0}}, 1'b1};
    return cap ? MAG_CAP : {1'b0, s[QUO_W:1]};
  endfunction

endpackage

### design/jsbm_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsbm_stream_if
// Valid/ready channels for the input matrices and the result word.
// ----------------------------------------------------------------------------
interface jsbm_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] a00, a01, a10, a11;
  logic signed [31:0] w00, w01, w10, w11;

  modport source (output valid, a00, a01, a10, a11, w00, w01, w10, w11,
                  input ready);
  modport sink   (input valid, a00, a01, a10, a11, w00, w01, w10, w11,
                  output ready);
endinterface

interface jsbm_out_if;
  logic               valid;
  logic               ready;
  logic               ok;
  logic signed [31:0] metric;
  logic signed [31:0] grad00, grad01, grad10, grad11;

  modport source (output valid, ok, metric, grad00, grad01, grad10, grad11,
                  input ready);
  modport sink   (input valid, ok, metric, grad00, grad01, grad10, grad11,
                  output ready);
endinterface

### design/jsbm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsbm_div
// Pipelined restoring divider, one quotient bit per stage, shared divisor
// across lanes; side-band word travels alongside.
// ----------------------------------------------------------------------------
module jsbm_div import jsbm_pkg::*; #(
  parameter int LANES = 1,
  parameter int SW    = 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [LANES-1:0][NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]             den,
  input  logic [SW-1:0]                side_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [LANES-1:0][QUO_W-1:0]  quo,
  output logic [LANES-1:0]             cap,
  output logic [SW-1:0]                side_out
);

  localparam int STEPS = QUO_W;

  logic [STEPS:0]   vld;
  logic [STEPS+1:0] en;

  logic [LANES-1:0][REM_W-1:0] rem [STEPS+1];
  logic [LANES-1:0][QUO_W-1:0] sh  [STEPS+1];
  logic [LANES-1:0]            cp  [STEPS+1];
  logic [DEN_W-1:0]            dv  [STEPS+1];
  logic [SW-1:0]               sd  [STEPS+1];

  logic [LANES-1:0][REM_W-1:0] trial    [1:STEPS];
  logic [LANES-1:0][REM_W-1:0] rem_next [1:STEPS];
  logic [LANES-1:0]            ge       [1:STEPS];

  assign en[STEPS+1] = out_ready;
  assign in_ready    = en[0];

  genvar s;
  generate
    for (s = 0; s <= STEPS; s++) begin : g_ctl
      assign en[s] = !vld[s] || en[s+1];
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[s] <= 1'b0;
        end else if (en[s]) begin
          vld[s] <= (s == 0) ? in_valid : vld[(s == 0) ? 0 : s-1];
        end
      end
    end

    // entry: leading dividend bits become the first remainder
    always_ff @(posedge clk) begin
      if (en[0]) begin
        for (int l = 0; l < LANES; l++) begin
          rem[0][l] <= REM_W'(num[l][NUM_W-1:QUO_W]);
          sh[0][l]  <= num[l][QUO_W-1:0];
          cp[0][l]  <= (REM_W'(num[l][NUM_W-1:QUO_W]) >= REM_W'(den));
        end
        dv[0] <= den;
        sd[0] <= side_in;
      end
    end

    for (s = 1; s <= STEPS; s++) begin : g_step
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          trial[s][l]    = {rem[s-1][l][REM_W-2:0], sh[s-1][l][QUO_W-1]};
          ge[s][l]       = trial[s][l] >= {1'b0, dv[s-1]};
          rem_next[s][l] = ge[s][l] ? trial[s][l] - {1'b0, dv[s-1]} : trial[s][l];
        end
      end
      always_ff @(posedge clk) begin
        if (en[s]) begin
          for (int l = 0; l < LANES; l++) begin
            rem[s][l] <= rem_next[s][l];
            sh[s][l]  <= {sh[s-1][l][QUO_W-2:0], ge[s][l]};
          end
          cp[s] <= cp[s-1];
          dv[s] <= dv[s-1];
          sd[s] <= sd[s-1];
        end
      end
    end
  endgenerate

  assign out_valid = vld[STEPS];
  assign quo       = sh[STEPS];
  assign cap       = cp[STEPS];
  assign side_out  = sd[STEPS];

`ifndef SYNTHESIS
  // a stalled quotient must not move
  a_hold: assert property (@(posedge clk) disable iff (rst)
    vld[STEPS] && !out_ready |=> vld[STEPS] && $stable(sh[STEPS]) && $stable(sd[STEPS]))
    else $error("divider output changed while stalled");
`endif

endmodule

### design/jsbm_grad.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsbm_grad
// Back end: 1/d rounding, 1 - 1/d^2, split products for the gradient,
// saturation and the output register.
// ----------------------------------------------------------------------------
module jsbm_grad import jsbm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [QUO_W-1:0] rq,
  input  logic             rcap,
  input  jsbm_side_t       side,
  jsbm_out_if.source       result
);

  logic [6:1] vld;
  logic [7:1] en;

  assign in_ready = en[1];

  always_comb begin
    en[7] = result.ready;
    for (int k = 6; k >= 1; k--) en[k] = !vld[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= in_valid;
      for (int k = 2; k <= 6; k++) if (en[k]) vld[k] <= vld[k-1];
    end
  end

  // g1: reciprocal
  logic [MAG_W-1:0]   recip_full;
  logic [RECIP_W-1:0] g1_recip;
  jsbm_side_t         g1_side;
  assign recip_full = round_cap(rq, rcap);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      g1_recip <= recip_full[RECIP_W-1:0];   // at most 2^32 for a valid word
      g1_side  <= side;
    end
  end

  // g2: square and metric sum
  logic [SQ_W-1:0] g2_rr;
  logic [63:0]     g2_msum;
  jsbm_side_t      g2_side;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      g2_rr   <= SQ_W'(g1_recip) * SQ_W'(g1_recip);
      g2_msum <= 64'(g1_side.dm) + 64'(g1_recip);
      g2_side <= g1_side;
    end
  end

  // g3: f = 1 - round(r^2 / 2^16)
  logic [SQ_W:0]    rr_rnd;
  logic [SQ_W-16:0] qv;
  logic             fneg;
  logic [SQ_W-16:0] fv;
  logic [FM_W-1:0]  g3_fm;
  logic             g3_fneg;
  logic [Q_W-1:0]   g3_metric;
  jsbm_side_t       g3_side;

  always_comb begin
    rr_rnd = {1'b0, g2_rr} + (SQ_W+1)'(ROUND_HALF);
    qv     = rr_rnd[SQ_W:16];
    fneg   = qv > (SQ_W-15)'(ONE_Q);
    fv     = fneg ? qv - (SQ_W-15)'(ONE_Q) : (SQ_W-15)'(ONE_Q) - qv;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      g3_fm     <= fv[FM_W-1:0];
      g3_fneg   <= fneg;
      g3_metric <= (|g2_msum[63:31]) ? SAT_POS : g2_msum[31:0];
      g3_side   <= g2_side;
    end
  end

  // g4: partial products fm * hm
  logic [H_LANES-1:0][63:0] g4_ll;
  logic [H_LANES-1:0][62:0] g4_lh;
  logic [H_LANES-1:0][48:0] g4_hl;
  logic [H_LANES-1:0][47:0] g4_hh;
  logic [H_LANES-1:0]       g4_gneg;
  logic [Q_W-1:0]           g4_metric;
  logic                     g4_ok;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int k = 0; k < H_LANES; k++) begin
        g4_ll[k]   <= 64'(g3_fm[31:0])  * 64'(g3_side.hm[k][31:0]);
        g4_lh[k]   <= 63'(g3_fm[31:0])  * 63'(g3_side.hm[k][62:32]);
        g4_hl[k]   <= 49'(g3_fm[48:32]) * 49'(g3_side.hm[k][31:0]);
        g4_hh[k]   <= 48'(g3_fm[48:32]) * 48'(g3_side.hm[k][62:32]);
        g4_gneg[k] <= g3_side.hneg[k] ^ g3_fneg;
      end
      g4_metric <= g3_metric;
      g4_ok     <= g3_side.ok;
    end
  end

  // g5: sum, round, cap
  logic [H_LANES-1:0][ACC_W-1:0] acc;
  logic [H_LANES-1:0][MAG_W-1:0] g5_gm;
  logic [H_LANES-1:0]            g5_gneg;
  logic [Q_W-1:0]                g5_metric;
  logic                          g5_ok;

  always_comb begin
    for (int k = 0; k < H_LANES; k++) begin
      acc[k] = ACC_W'(g4_ll[k]) + (ACC_W'(g4_lh[k]) << 32) + (ACC_W'(g4_hl[k]) << 32)
             + (ACC_W'(g4_hh[k]) << 64) + ACC_W'(ROUND_HALF);
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int k = 0; k < H_LANES; k++) begin
        g5_gm[k] <= (|acc[k][ACC_W-1:78]) ? MAG_CAP : {1'b0, acc[k][77:16]};
      end
      g5_gneg   <= g4_gneg;
      g5_metric <= g4_metric;
      g5_ok     <= g4_ok;
    end
  end

  // g6: signed saturation, zero on invalid
  logic [H_LANES-1:0][Q_W-1:0] sat;
  logic [H_LANES-1:0][Q_W-1:0] g6_grad;
  logic [Q_W-1:0]              g6_metric;
  logic                        g6_ok;

  always_comb begin
    for (int k = 0; k < H_LANES; k++) begin
      if (g5_gneg[k]) begin
        sat[k] = (g5_gm[k] > MAG_W'(SAT_NEG)) ? SAT_NEG : (~g5_gm[k][31:0] + 32'd1);
      end else begin
        sat[k] = (g5_gm[k] > MAG_W'(SAT_POS)) ? SAT_POS : g5_gm[k][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      g6_ok     <= g5_ok;
      g6_metric <= g5_ok ? g5_metric : '0;
      for (int k = 0; k < H_LANES; k++) g6_grad[k] <= g5_ok ? sat[k] : '0;
    end
  end

  assign result.valid  = vld[6];
  assign result.ok     = g6_ok;
  assign result.metric = g6_metric;
  assign result.grad00 = g6_grad[0];
  assign result.grad01 = g6_grad[1];
  assign result.grad10 = g6_grad[2];
  assign result.grad11 = g6_grad[3];

endmodule

### design/jacobian_size_barrier_metric_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jacobian_size_barrier_metric_top
// Size barrier metric d + 1/d of A * inv(W) and its gradient, Q16.16.
// ----------------------------------------------------------------------------
// Pipeline: 2 front stages, two 63-register dividers, 1 rounding stage,
//   6 back-end stages.
// Throughput: one word per cycle while result.ready does not stall; the two
//   62-stage restoring dividers, one quotient bit per stage, set the depth.
// Reset (rst, synchronous): clears all valid bits and sets min_determinant
//   to 1; no clearing pass.
module jacobian_size_barrier_metric_top import jsbm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  jsbm_in_if.sink           item,
  jsbm_out_if.source        result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // ---------------- configuration ----------------
  logic [MIN_W-1:0] min_det;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_det <= MIN_DET_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_MIN_DET) begin
      min_det <= pwdata[MIN_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_MIN_DET) ? {1'b0, min_det} : '0;

  // ---------------- front: products, determinants ----------------
  logic        vld1, vld2;
  logic        en1, en2;
  logic        d1_in_ready;

  logic signed [Q_W-1:0]   s1_a00, s1_a01, s1_a10, s1_a11;
  logic signed [DET_W-1:0] s1_pa0, s1_pa1, s1_pw0, s1_pw1;
  logic signed [Q_W-1:0]   s2_a00, s2_a01, s2_a10, s2_a11;
  logic signed [DET_W-1:0] s2_deta, s2_detw;

  assign en2        = !vld2 || d1_in_ready;
  assign en1        = !vld1 || en2;
  assign item.ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
    end else begin
      if (en1) vld1 <= item.valid;
      if (en2) vld2 <= vld1;
    end
  end

  // stage 1: four 32x32 signed products
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_pa0 <= DET_W'(item.a00) * DET_W'(item.a11);
      s1_pa1 <= DET_W'(item.a01) * DET_W'(item.a10);
      s1_pw0 <= DET_W'(item.w00) * DET_W'(item.w11);
      s1_pw1 <= DET_W'(item.w01) * DET_W'(item.w10);
      s1_a00 <= item.a00;
      s1_a01 <= item.a01;
      s1_a10 <= item.a10;
      s1_a11 <= item.a11;
    end
  end

  // stage 2: exact determinants (never overflow 64 bits)
  always_ff @(posedge clk) begin
    if (en2) begin
      s2_deta <= s1_pa0 - s1_pa1;
      s2_detw <= s1_pw0 - s1_pw1;
      s2_a00  <= s1_a00;
      s2_a01  <= s1_a01;
      s2_a10  <= s1_a10;
      s2_a11  <= s1_a11;
    end
  end

  // divider operands: lane 0 is d (16 fraction bits + guard),
  // lanes 1..4 are cof(A)/detW (16 fraction bits + guard)
  logic [DET_W-1:0]                  mag_a, mag_w;
  logic [H_LANES-1:0][Q_W-1:0]       mag_c;
  logic [H_LANES-1:0]                cneg;
  logic [H_LANES:0][NUM_W-1:0]       d1_num;
  jsbm_pre_t                         pre;
  logic                              wneg;

  always_comb begin
    wneg     = s2_detw[DET_W-1];
    mag_a    = s2_deta[DET_W-1] ? -s2_deta : s2_deta;
    mag_w    = wneg ? -s2_detw : s2_detw;
    // cof(A) = [[a11, -a10], [-a01, a00]]
    mag_c[0] = s2_a11[Q_W-1] ? -s2_a11 : s2_a11;
    mag_c[1] = s2_a10[Q_W-1] ? -s2_a10 : s2_a10;
    mag_c[2] = s2_a01[Q_W-1] ? -s2_a01 : s2_a01;
    mag_c[3] = s2_a00[Q_W-1] ? -s2_a00 : s2_a00;
    cneg[0]  = s2_a11 < 0;
    cneg[1]  = s2_a10 > 0;
    cneg[2]  = s2_a01 > 0;
    cneg[3]  = s2_a00 < 0;
    d1_num[0] = {16'd0, mag_a, 17'd0};
    for (int k = 0; k < H_LANES; k++) d1_num[k+1] = {32'd0, mag_c[k], 33'd0};
    pre.wzero = (s2_detw == '0);
    pre.dneg  = s2_deta[DET_W-1] != wneg;
    pre.hneg  = cneg ^ {H_LANES{wneg}};
  end

  logic                          d1_out_valid, en3;
  logic [H_LANES:0][QUO_W-1:0]   d1_quo;
  logic [H_LANES:0]              d1_cap;
  jsbm_pre_t                     d1_pre;

  jsbm_div #(.LANES(H_LANES + 1), .SW($bits(jsbm_pre_t))) u_div_h (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld2),
    .in_ready  (d1_in_ready),
    .num       (d1_num),
    .den       (mag_w),
    .side_in   (pre),
    .out_valid (d1_out_valid),
    .out_ready (en3),
    .quo       (d1_quo),
    .cap       (d1_cap),
    .side_out  (d1_pre)
  );

  // ---------------- stage 3: round d and h, validity ----------------
  logic             vld3;
  logic             d2_in_ready;
  logic [MAG_W-1:0] dm_c;
  jsbm_side_t       s3_side;

  assign en3  = !vld3 || d2_in_ready;
  assign dm_c = round_cap(d1_quo[0], d1_cap[0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld3 <= 1'b0;
    end else if (en3) begin
      vld3 <= d1_out_valid;
    end
  end

  // invalid: singular target, negative or zero d, or d below the minimum
  always_ff @(posedge clk) begin
    if (en3) begin
      s3_side.ok   <= !d1_pre.wzero && !d1_pre.dneg && dm_c != '0
                      && dm_c >= MAG_W'(min_det);
      s3_side.dm   <= dm_c;
      for (int k = 0; k < H_LANES; k++) begin
        s3_side.hm[k] <= round_cap(d1_quo[k+1], d1_cap[k+1]);
      end
      s3_side.hneg <= d1_pre.hneg;
    end
  end

  // ---------------- reciprocal divider: 2^32 / d ----------------
  logic                  d2_out_valid, g_in_ready;
  logic [0:0][NUM_W-1:0] d2_num;
  logic [0:0][QUO_W-1:0] d2_quo;
  logic [0:0]            d2_cap;
  jsbm_side_t            d2_side;

  assign d2_num[0] = NUM_W'(1) << 33;

  jsbm_div #(.LANES(1), .SW($bits(jsbm_side_t))) u_div_r (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld3),
    .in_ready  (d2_in_ready),
    .num       (d2_num),
    .den       ({1'b0, s3_side.dm}),
    .side_in   (s3_side),
    .out_valid (d2_out_valid),
    .out_ready (g_in_ready),
    .quo       (d2_quo),
    .cap       (d2_cap),
    .side_out  (d2_side)
  );

  // ---------------- back end ----------------
  jsbm_grad u_grad (
    .clk      (clk),
    .rst      (rst),
    .in_valid (d2_out_valid),
    .in_ready (g_in_ready),
    .rq       (d2_quo[0]),
    .rcap     (d2_cap[0]),
    .side     (d2_side),
    .result   (result)
  );

`ifndef SYNTHESIS
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ok |-> result.metric == 0 && result.grad00 == 0 &&
      result.grad01 == 0 && result.grad10 == 0 && result.grad11 == 0)
    else $error("invalid word carries nonzero payload");
  a_metric_pos: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.ok |-> !result.metric[31])
    else $error("valid word with negative metric");
  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && paddr[2] == REG_MIN_DET |=>
      min_det == $past(pwdata[MIN_W-1:0]))
    else $error("min_determinant write lost");
`endif

endmodule
